/* rtl/brfs_pkg.sv */
package brfs_pkg;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_DROP = 3'd2;
  localparam logic [2:0] OP_FIND = 3'd3;
  localparam logic [2:0] OP_GET  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  typedef enum logic [2:0] {
    K_PUSH,
    K_READ,
    K_DROP,
    K_FIND,
    K_GET,
    K_BAD
  } kind_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_in;
    logic [7:0] count;
    logic       consume;
  } req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [7:0] found_index;
    logic [1:0] status;
    logic       last;
    logic [7:0] occupancy;
  } res_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] count;
    logic       consume;
  } cmd_t;

endpackage

/* rtl/byte_ring_fifo_with_search_unit.sv */
// Channel   | Signals                              | Accepted when
// ----------+--------------------------------------+-------------------------------
// request   | start_i, busy_o, req_i               | start_i high and busy_o low
// result    | res_valid_o, res_o                   | every cycle res_valid_o is high
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i and cfg_ready_o high
//
// Push, drop, rejected requests and a find on an empty ring complete in the idle state
// of the execution unit. A get that hits, a burst read and a find on a nonempty ring
// step through the byte store one read at a time; its single read port sets their pace.
// A two-entry request queue lets new requests in while a long one executes.
// Reset empties the queue and sets the ring size to its largest value.
// The receiver cannot stall; configuration is taken only when all is idle.
module byte_ring_fifo_with_search_unit #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  brfs_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output brfs_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [8:0]     cfg_data_i
);
  import brfs_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic back_idle;

  assign cfg_ready_o = back_idle && !cmd_valid;

  brfs_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  brfs_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .idle_o     (back_idle),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

/* rtl/brfs_front.sv */
module brfs_front #(
  parameter int MAX_BURST = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  brfs_pkg::req_t req_i,
  output logic          busy_o,
  output logic          cmd_valid_o,
  output brfs_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import brfs_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.data    = req_i.data_in;
    cmd_in.count   = req_i.count;
    cmd_in.consume = req_i.consume;
    case (req_i.opcode)
      OP_PUSH: cmd_in.kind = K_PUSH;
      OP_READ: begin
        if ((req_i.count == 8'd0) || (req_i.count > 8'(MAX_BURST))) begin
          cmd_in.kind = K_BAD;
        end else begin
          cmd_in.kind = K_READ;
        end
      end
      OP_DROP: cmd_in.kind = K_DROP;
      OP_FIND: cmd_in.kind = K_FIND;
      OP_GET:  cmd_in.kind = K_GET;
      default: cmd_in.kind = K_BAD;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/brfs_back.sv */
module brfs_back #(
  parameter int DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  brfs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           idle_o,
  input  logic           cfg_we_i,
  input  logic [8:0]     cfg_data_i,
  output logic           res_valid_o,
  output brfs_pkg::res_t res_o
);
  import brfs_pkg::*;

  localparam int MEM_DEPTH = (DEPTH < 256) ? DEPTH : 256;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BURST = 2'd1;
  localparam logic [1:0] S_FIND  = 2'd2;

  logic [7:0] mem [MEM_DEPTH];

  logic [1:0] state_q, state_d;
  logic [8:0] rs_q, rs_d;
  logic [7:0] rp_q, rp_d;
  logic [7:0] wp_q, wp_d;
  logic [7:0] occ_q, occ_d;
  logic [7:0] ptr_q, ptr_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] iss_q, iss_d;
  logic [7:0] key_q, key_d;
  logic       rd_vld_q, rd_vld_d;
  logic       rd_last_q, rd_last_d;
  logic [7:0] rd_idx_q, rd_idx_d;
  logic [7:0] rd_data_q;
  logic       res_valid_q, res_valid_d;
  res_t       res_q, res_d;

  logic       mem_we;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic       rd_en;
  logic [7:0] rd_addr;
  logic [7:0] drop_n;

  function automatic logic [7:0] wrap_add(input logic [7:0] a, input logic [7:0] b,
                                          input logic [8:0] rs);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= rs) begin
      sum = sum - rs;
    end
    return sum[7:0];
  endfunction

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign drop_n      = (cmd_i.count > occ_q) ? occ_q : cmd_i.count;

  always_comb begin
    state_d     = state_q;
    rs_d        = rs_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    occ_d       = occ_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    iss_d       = iss_q;
    key_d       = key_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = rd_last_q;
    rd_idx_d    = rd_idx_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = wp_q;
    mem_wdata   = cmd_i.data;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    cmd_pop_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o   = 1'b1;
          res_valid_d = 1'b1;
          case (cmd_i.kind)
            K_PUSH: begin
              if (({1'b0, occ_q} + 9'd1) < rs_q) begin
                mem_we       = 1'b1;
                wp_d         = wrap_add(wp_q, 8'd1, rs_q);
                occ_d        = occ_q + 8'd1;
                res_d.status = ST_OK;
              end else begin
                res_d.status = ST_FULL;
              end
            end
            K_DROP: begin
              rp_d         = wrap_add(rp_q, drop_n, rs_q);
              occ_d        = occ_q - drop_n;
              res_d.status = ST_OK;
            end
            K_GET: begin
              if (cmd_i.count < occ_q) begin
                res_valid_d = 1'b0;
                rd_en       = 1'b1;
                rd_addr     = wrap_add(rp_q, cmd_i.count, rs_q);
                rd_vld_d    = 1'b1;
                rd_last_d   = 1'b1;
                rem_d       = 8'd0;
                state_d     = S_BURST;
              end else begin
                res_d.status = ST_MISS;
              end
            end
            K_READ: begin
              if (cmd_i.count > occ_q) begin
                res_d.status = ST_MISS;
              end else begin
                res_valid_d = 1'b0;
                ptr_d       = rp_q;
                rem_d       = cmd_i.count;
                state_d     = S_BURST;
                if (cmd_i.consume) begin
                  rp_d  = wrap_add(rp_q, cmd_i.count, rs_q);
                  occ_d = occ_q - cmd_i.count;
                end
              end
            end
            K_FIND: begin
              if (occ_q == 8'd0) begin
                res_d.status = ST_MISS;
              end else begin
                res_valid_d = 1'b0;
                key_d       = cmd_i.data;
                ptr_d       = rp_q;
                iss_d       = 8'd0;
                state_d     = S_FIND;
              end
            end
            default: begin
              res_d.status = ST_BADLEN;
            end
          endcase
          res_d.occupancy = occ_d;
        end
      end
      S_BURST: begin
        if (rem_q != 8'd0) begin
          rd_en     = 1'b1;
          ptr_d     = wrap_add(ptr_q, 8'd1, rs_q);
          rem_d     = rem_q - 8'd1;
          rd_vld_d  = 1'b1;
          rd_last_d = (rem_q == 8'd1);
        end
        if (rd_vld_q) begin
          res_valid_d     = 1'b1;
          res_d.data_out  = rd_data_q;
          res_d.status    = ST_OK;
          res_d.last      = rd_last_q;
          res_d.occupancy = occ_q;
          if (rd_last_q) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FIND: begin
        if (iss_q != occ_q) begin
          rd_en    = 1'b1;
          ptr_d    = wrap_add(ptr_q, 8'd1, rs_q);
          iss_d    = iss_q + 8'd1;
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q;
        end
        if (rd_vld_q) begin
          res_d.occupancy = occ_q;
          if (rd_data_q == key_q) begin
            res_valid_d       = 1'b1;
            res_d.status      = ST_OK;
            res_d.found_index = rd_idx_q;
            rd_vld_d          = 1'b0;
            state_d           = S_IDLE;
          end else if (rd_idx_q == (occ_q - 8'd1)) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_MISS;
            rd_vld_d     = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_data_i < 9'd2) begin
        rs_d = 9'd2;
      end else if (cfg_data_i > 9'(MEM_DEPTH)) begin
        rs_d = 9'(MEM_DEPTH);
      end else begin
        rs_d = cfg_data_i;
      end
      rp_d  = 8'd0;
      wp_d  = 8'd0;
      occ_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rs_q        <= 9'(MEM_DEPTH);
      rp_q        <= 8'd0;
      wp_q        <= 8'd0;
      occ_q       <= 8'd0;
      ptr_q       <= 8'd0;
      rem_q       <= 8'd0;
      iss_q       <= 8'd0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rs_q        <= rs_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      occ_q       <= occ_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rd_last_q <= rd_last_d;
    rd_idx_q  <= rd_idx_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr[AW-1:0]];
    end
  end

endmodule

/* rtl/brfs_chk.sv */
module brfs_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input brfs_pkg::req_t req_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input brfs_pkg::res_t res_o,
  input logic           cfg_valid_i,
  input logic           cfg_ready_o,
  input logic [8:0]     cfg_data_i
);
  import brfs_pkg::*;

  // A configuration write leaves nothing in flight.
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !res_valid_o)
    else $error("result after configuration write");

  // Burst results come in consecutive cycles.
  a_burst_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> res_valid_o)
    else $error("gap inside burst");

  // Occupancy does not change within one burst.
  a_burst_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> $stable(res_o.occupancy))
    else $error("occupancy changed within burst");

  // A rejected push only happens on a nonempty ring.
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status == ST_FULL)) |-> (res_o.occupancy != 8'd0))
    else $error("full status on empty ring");

endmodule

bind byte_ring_fifo_with_search_unit brfs_chk u_brfs_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .req_i      (req_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o),
  .cfg_data_i (cfg_data_i)
);
